/* src/sc1kd_pkg.sv */
// Shared types, constants and character ROM for the set-1 scan code decoder.
package sc1kd_pkg;

   localparam logic [7:0] CODE_PAUSE_START = 8'hE1;
   localparam logic [7:0] CODE_EXT_PREFIX  = 8'hE0;
   localparam logic [7:0] CODE_PAUSE_2     = 8'h1D;
   localparam logic [7:0] CODE_PAUSE_3     = 8'h45;
   localparam logic [7:0] CODE_PAUSE_5     = 8'h9D;
   localparam logic [7:0] CODE_PAUSE_6     = 8'hC5;
   localparam logic [7:0] CODE_PRTSC_MAKE1 = 8'h2A;
   localparam logic [7:0] CODE_PRTSC_BRK1  = 8'hB7;
   localparam logic [7:0] CODE_PRTSC_MAKE2 = 8'h37;
   localparam logic [7:0] CODE_PRTSC_BRK2  = 8'hAA;
   localparam logic [7:0] CODE_CTRL_MAKE   = 8'h1D;
   localparam logic [7:0] CODE_CTRL_BRK    = 8'h9D;
   localparam logic [7:0] CODE_ALT_MAKE    = 8'h38;
   localparam logic [7:0] CODE_ALT_BRK     = 8'hB8;

   localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
   localparam logic [6:0] KEY_SHIFT_R = 7'h36;
   localparam logic [6:0] KEY_CTRL_L  = 7'h1D;
   localparam logic [6:0] KEY_ALT_L   = 7'h38;

   // modifier flag bit positions
   localparam int FLAG_SHIFT_L = 0;
   localparam int FLAG_SHIFT_R = 1;
   localparam int FLAG_CTRL_L  = 2;
   localparam int FLAG_CTRL_R  = 3;
   localparam int FLAG_ALT_L   = 4;
   localparam int FLAG_ALT_R   = 5;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_CHAR  = 3'd1,
      KIND_PRTSC = 3'd2,
      KIND_PAUSE = 3'd3,
      KIND_OTHER = 3'd4
   } kind_type;

   typedef enum logic [10:0] {
      PH_IDLE   = 11'b000_0000_0001,
      PH_PAUSE1 = 11'b000_0000_0010,
      PH_PAUSE2 = 11'b000_0000_0100,
      PH_PAUSE3 = 11'b000_0000_1000,
      PH_PAUSE4 = 11'b000_0001_0000,
      PH_PAUSE5 = 11'b000_0010_0000,
      PH_EXT    = 11'b000_0100_0000,
      PH_PSP1   = 11'b000_1000_0000,
      PH_PSP2   = 11'b001_0000_0000,
      PH_PSR1   = 11'b010_0000_0000,
      PH_PSR2   = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] key_char;
      logic       pressed;
      logic       shift_held;
      logic       ctrl_held;
      logic       alt_held;
   } result_type;

   // returns {shifted, unshifted}
   function automatic logic [13:0] char_rom(input logic [6:0] code);
      logic [13:0] e;
      case (code)
         7'h02: e = {7'h21, 7'h31};
         7'h03: e = {7'h40, 7'h32};
         7'h04: e = {7'h23, 7'h33};
         7'h05: e = {7'h24, 7'h34};
         7'h06: e = {7'h25, 7'h35};
         7'h07: e = {7'h5E, 7'h36};
         7'h08: e = {7'h26, 7'h37};
         7'h09: e = {7'h2A, 7'h38};
         7'h0A: e = {7'h28, 7'h39};
         7'h0B: e = {7'h29, 7'h30};
         7'h0C: e = {7'h5F, 7'h2D};
         7'h0D: e = {7'h2B, 7'h3D};
         7'h0E: e = {7'h08, 7'h08};
         7'h0F: e = {7'h09, 7'h09};
         7'h10: e = {7'h51, 7'h71};
         7'h11: e = {7'h57, 7'h77};
         7'h12: e = {7'h45, 7'h65};
         7'h13: e = {7'h52, 7'h72};
         7'h14: e = {7'h54, 7'h74};
         7'h15: e = {7'h59, 7'h79};
         7'h16: e = {7'h55, 7'h75};
         7'h17: e = {7'h49, 7'h69};
         7'h18: e = {7'h4F, 7'h6F};
         7'h19: e = {7'h50, 7'h70};
         7'h1A: e = {7'h7B, 7'h5B};
         7'h1B: e = {7'h7D, 7'h5D};
         7'h1C: e = {7'h0A, 7'h0A};
         7'h1D: e = {7'h1D, 7'h1D};
         7'h1E: e = {7'h41, 7'h61};
         7'h1F: e = {7'h53, 7'h73};
         7'h20: e = {7'h44, 7'h64};
         7'h21: e = {7'h46, 7'h66};
         7'h22: e = {7'h47, 7'h67};
         7'h23: e = {7'h48, 7'h68};
         7'h24: e = {7'h4A, 7'h6A};
         7'h25: e = {7'h4B, 7'h6B};
         7'h26: e = {7'h4C, 7'h6C};
         7'h27: e = {7'h3A, 7'h3B};
         7'h28: e = {7'h22, 7'h27};
         7'h29: e = {7'h7E, 7'h60};
         7'h2A: e = {7'h2A, 7'h2A};
         7'h2B: e = {7'h7C, 7'h5C};
         7'h2C: e = {7'h5A, 7'h7A};
         7'h2D: e = {7'h58, 7'h78};
         7'h2E: e = {7'h43, 7'h63};
         7'h2F: e = {7'h56, 7'h76};
         7'h30: e = {7'h42, 7'h62};
         7'h31: e = {7'h4E, 7'h6E};
         7'h32: e = {7'h4D, 7'h6D};
         7'h33: e = {7'h3C, 7'h2C};
         7'h34: e = {7'h3E, 7'h2E};
         7'h35: e = {7'h3F, 7'h2F};
         7'h36: e = {7'h36, 7'h36};
         7'h37: e = {7'h2A, 7'h2A};
         7'h38: e = {7'h38, 7'h38};
         7'h39: e = {7'h20, 7'h20};
         // keypad: no shifted entry
         7'h47: e = {7'h00, 7'h37};
         7'h48: e = {7'h00, 7'h38};
         7'h49: e = {7'h00, 7'h39};
         7'h4A: e = {7'h00, 7'h2D};
         7'h4B: e = {7'h00, 7'h34};
         7'h4C: e = {7'h00, 7'h35};
         7'h4D: e = {7'h00, 7'h36};
         7'h4E: e = {7'h00, 7'h2B};
         7'h4F: e = {7'h00, 7'h31};
         7'h50: e = {7'h00, 7'h32};
         7'h51: e = {7'h00, 7'h33};
         7'h52: e = {7'h00, 7'h30};
         7'h53: e = {7'h00, 7'h2E};
         default: e = 14'd0;
      endcase
      return e;
   endfunction

endpackage

/* src/sc1kd_decode.sv */
// Next-state and result logic for one scan code byte.
module sc1kd_decode (
   input  sc1kd_pkg::phase_type  phase,
   input  logic [5:0]            flags,
   input  logic [7:0]            scan_code,
   output sc1kd_pkg::phase_type  phase_next,
   output logic [5:0]            flags_next,
   output logic                  emit,
   output sc1kd_pkg::result_type result
);

   sc1kd_pkg::kind_type kind;
   logic [6:0]          key_char;
   logic                pressed;
   logic [6:0]          code;
   logic                make;
   logic [13:0]         rom_entry;
   logic [6:0]          rom_char;

   assign code      = scan_code[6:0];
   assign make      = ~scan_code[7];
   assign rom_entry = sc1kd_pkg::char_rom(code);
   // shifted column selected by the flags held before this byte
   assign rom_char  = (flags[sc1kd_pkg::FLAG_SHIFT_L] | flags[sc1kd_pkg::FLAG_SHIFT_R])
                      ? rom_entry[13:7] : rom_entry[6:0];

   always_comb begin
      phase_next = sc1kd_pkg::PH_IDLE;
      flags_next = flags;
      emit       = 1'b0;
      kind       = sc1kd_pkg::KIND_NONE;
      key_char   = 7'd0;
      pressed    = 1'b0;
      case (phase)
         sc1kd_pkg::PH_PAUSE1: begin
            if (scan_code == sc1kd_pkg::CODE_PAUSE_2) phase_next = sc1kd_pkg::PH_PAUSE2;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PAUSE2: begin
            if (scan_code == sc1kd_pkg::CODE_PAUSE_3) phase_next = sc1kd_pkg::PH_PAUSE3;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PAUSE3: begin
            if (scan_code == sc1kd_pkg::CODE_PAUSE_START) phase_next = sc1kd_pkg::PH_PAUSE4;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PAUSE4: begin
            if (scan_code == sc1kd_pkg::CODE_PAUSE_5) phase_next = sc1kd_pkg::PH_PAUSE5;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PAUSE5: begin
            emit = 1'b1;
            if (scan_code == sc1kd_pkg::CODE_PAUSE_6) kind = sc1kd_pkg::KIND_PAUSE;
         end
         sc1kd_pkg::PH_EXT: begin
            if (scan_code == sc1kd_pkg::CODE_PRTSC_MAKE1) begin
               phase_next = sc1kd_pkg::PH_PSP1;
            end else if (scan_code == sc1kd_pkg::CODE_PRTSC_BRK1) begin
               phase_next = sc1kd_pkg::PH_PSR1;
            end else begin
               emit = 1'b1;
               kind = sc1kd_pkg::KIND_OTHER;
               if (scan_code == sc1kd_pkg::CODE_CTRL_MAKE)
                  flags_next[sc1kd_pkg::FLAG_CTRL_R] = 1'b1;
               if (scan_code == sc1kd_pkg::CODE_CTRL_BRK)
                  flags_next[sc1kd_pkg::FLAG_CTRL_R] = 1'b0;
               if (scan_code == sc1kd_pkg::CODE_ALT_MAKE)
                  flags_next[sc1kd_pkg::FLAG_ALT_R] = 1'b1;
               if (scan_code == sc1kd_pkg::CODE_ALT_BRK)
                  flags_next[sc1kd_pkg::FLAG_ALT_R] = 1'b0;
            end
         end
         sc1kd_pkg::PH_PSP1: begin
            if (scan_code == sc1kd_pkg::CODE_EXT_PREFIX) phase_next = sc1kd_pkg::PH_PSP2;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PSR1: begin
            if (scan_code == sc1kd_pkg::CODE_EXT_PREFIX) phase_next = sc1kd_pkg::PH_PSR2;
            else emit = 1'b1;
         end
         sc1kd_pkg::PH_PSP2: begin
            emit = 1'b1;
            if (scan_code == sc1kd_pkg::CODE_PRTSC_MAKE2) begin
               kind    = sc1kd_pkg::KIND_PRTSC;
               pressed = 1'b1;
            end
         end
         sc1kd_pkg::PH_PSR2: begin
            emit = 1'b1;
            if (scan_code == sc1kd_pkg::CODE_PRTSC_BRK2) kind = sc1kd_pkg::KIND_PRTSC;
         end
         default: begin
            // idle
            if (scan_code == sc1kd_pkg::CODE_PAUSE_START) begin
               phase_next = sc1kd_pkg::PH_PAUSE1;
            end else if (scan_code == sc1kd_pkg::CODE_EXT_PREFIX) begin
               phase_next = sc1kd_pkg::PH_EXT;
            end else begin
               emit = 1'b1;
               case (code)
                  sc1kd_pkg::KEY_SHIFT_L: flags_next[sc1kd_pkg::FLAG_SHIFT_L] = make;
                  sc1kd_pkg::KEY_SHIFT_R: flags_next[sc1kd_pkg::FLAG_SHIFT_R] = make;
                  sc1kd_pkg::KEY_CTRL_L:  flags_next[sc1kd_pkg::FLAG_CTRL_L]  = make;
                  sc1kd_pkg::KEY_ALT_L:   flags_next[sc1kd_pkg::FLAG_ALT_L]   = make;
                  default: begin
                     if (make && (rom_char != 7'd0)) begin
                        kind     = sc1kd_pkg::KIND_CHAR;
                        key_char = rom_char;
                        pressed  = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   assign result.kind       = kind;
   assign result.key_char   = key_char;
   assign result.pressed    = pressed;
   assign result.shift_held = flags_next[sc1kd_pkg::FLAG_SHIFT_L]
                              | flags_next[sc1kd_pkg::FLAG_SHIFT_R];
   assign result.ctrl_held  = flags_next[sc1kd_pkg::FLAG_CTRL_L]
                              | flags_next[sc1kd_pkg::FLAG_CTRL_R];
   assign result.alt_held   = flags_next[sc1kd_pkg::FLAG_ALT_L]
                              | flags_next[sc1kd_pkg::FLAG_ALT_R];

endmodule

/* src/sc1kd_rsp_reg.sv */
// Result register with valid/stall handshake toward the receiver.
module sc1kd_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sc1kd_pkg::result_type load_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output sc1kd_pkg::result_type rsp_data,
   output logic                  free
);

   logic                  valid_ff;
   logic                  valid_in;
   sc1kd_pkg::result_type data_ff;

   // slot can take a new result if empty or being drained this cycle
   assign free     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* src/scan_code_set1_key_decoder.sv */
// Top level of the set-1 scan code decoder.
//
// Input channel (req_): one scan code byte per transaction, accepted when
// req_valid is high and req_stall is low. Output channel (rsp_): one decoded
// result per completed sequence (prefix bytes give no result), taken when
// rsp_valid is high and rsp_stall is low.
//
// A byte is captured in an input register, decoded against the sequence
// phase and modifier flags, and the result lands in an output register,
// which drives rsp_valid. One byte per cycle is accepted as long as the
// result register drains.
//
// When the receiver stalls, the held result stays put; the input register
// still moves bytes that produce no result, and a byte that would produce one
// waits, raising req_stall. Reset clears the phase to idle, all modifier
// flags to released and both registers to empty.
module scan_code_set1_key_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [6:0] rsp_key_char,
   output logic       rsp_pressed,
   output logic       rsp_shift_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_alt_held
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [7:0]            in_code_ff;
   sc1kd_pkg::phase_type  phase_ff;
   sc1kd_pkg::phase_type  phase_in;
   logic [5:0]            flags_ff;
   logic [5:0]            flags_in;
   logic                  emit;
   logic                  advance;
   logic                  rsp_free;
   sc1kd_pkg::result_type result;
   sc1kd_pkg::result_type rsp_data;

   sc1kd_decode u_decode (
      .phase      (phase_ff),
      .flags      (flags_ff),
      .scan_code  (in_code_ff),
      .phase_next (phase_in),
      .flags_next (flags_in),
      .emit       (emit),
      .result     (result)
   );

   // byte retires when it has no result or the result slot can take it
   assign advance     = in_valid_ff & (~emit | rsp_free);
   assign req_stall   = in_valid_ff & ~advance;
   assign in_valid_in = req_valid | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= sc1kd_pkg::PH_IDLE;
         flags_ff    <= 6'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_code_ff <= req_scan_code;
      end
   end

   sc1kd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & emit),
      .load_data (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (rsp_free)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_key_char   = rsp_data.key_char;
   assign rsp_pressed    = rsp_data.pressed;
   assign rsp_shift_held = rsp_data.shift_held;
   assign rsp_ctrl_held  = rsp_data.ctrl_held;
   assign rsp_alt_held   = rsp_data.alt_held;

endmodule

/* src/sc1kd_checker.sv */
// Port-level assertions for the scan code decoder, bound to the top level.
module sc1kd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [6:0] rsp_key_char,
   input logic       rsp_pressed,
   input logic       rsp_shift_held,
   input logic       rsp_ctrl_held,
   input logic       rsp_alt_held
);

   // nothing comes out and nothing is held off the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> (!rsp_valid && !req_stall))
      else $error("rsp_valid or req_stall after reset");

   // character only for non-character kinds is zero
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != sc1kd_pkg::KIND_CHAR)) |-> (rsp_key_char == 7'd0))
      else $error("key_char set on non-character result");

   // a character result is always a press of a mapped key
   a_char_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sc1kd_pkg::KIND_CHAR))
      |-> (rsp_pressed && (rsp_key_char != 7'd0)))
      else $error("character result without press or code");

   // only print screen and characters report pressed
   a_pressed_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressed)
      |-> ((rsp_kind == sc1kd_pkg::KIND_CHAR) || (rsp_kind == sc1kd_pkg::KIND_PRTSC)))
      else $error("pressed on wrong kind");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind)
      && $stable(rsp_key_char) && $stable(rsp_pressed) && $stable(rsp_shift_held)
      && $stable(rsp_ctrl_held) && $stable(rsp_alt_held)))
      else $error("stalled transaction changed");

endmodule

bind scan_code_set1_key_decoder sc1kd_checker u_sc1kd_checker (.*);
